// ===== hdl/bts_pkg.sv =====
// Shared constants and helpers for the bilinear texel sampler.
// No dependencies; every other file of the block uses this package.
package bts_pkg;

  // Store geometry.
  localparam int MAX_EDGE       = 64;
  localparam int MAX_COMPONENTS = 4;
  localparam int STORE_DEPTH    = MAX_EDGE * MAX_EDGE * MAX_COMPONENTS;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int COORD_W        = $clog2(MAX_EDGE);
  localparam int ROW_W          = 2 * COORD_W;

  // Field widths.
  localparam int EDGE_W   = 7;
  localparam int STRIDE_W = 3;
  localparam int CFG_W    = 7;
  localparam int POS_W    = 18;
  localparam int TEXEL_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int COMP_W   = 2;

  // Fixed-point constants.
  localparam int HALF_TEXEL = 32768;

  // Register indexes.
  localparam logic CFG_EDGE   = 1'b0;
  localparam logic CFG_STRIDE = 1'b1;

  // Item kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

endpackage

// ===== hdl/bts_in_if.sv =====
// Input channel of the texel sampler: valid/ready plus the input word.
// Depends on bts_pkg for field widths.
interface bts_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [bts_pkg::ADDR_W-1:0]          store_address;
  logic signed [bts_pkg::TEXEL_W-1:0]  store_value;
  logic signed [bts_pkg::POS_W-1:0]    pos_x;
  logic signed [bts_pkg::POS_W-1:0]    pos_y;
  logic [bts_pkg::COMP_W-1:0]          component;

  modport source (output valid, kind, store_address, store_value, pos_x, pos_y, component,
                  input ready);
  modport sink   (input valid, kind, store_address, store_value, pos_x, pos_y, component,
                  output ready);
endinterface

// ===== hdl/bts_out_if.sv =====
// Result channel of the texel sampler: valid/ready plus the sample word.
// Depends on bts_pkg for field widths.
interface bts_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bts_pkg::TEXEL_W-1:0]  sample_value;

  modport source (output valid, sample_value, input ready);
  modport sink   (input valid, sample_value, output ready);
endinterface

// ===== hdl/bts_coord.sv =====
// One axis of the address front end: scale, half-texel shift and clamp.
// Two register stages; depends on bts_pkg.
module bts_coord (
  input  logic                                clk,
  input  logic                                en_a,
  input  logic                                en_b,
  input  logic signed [bts_pkg::POS_W-1:0]    pos,
  input  logic [bts_pkg::EDGE_W-1:0]          edge_len,
  output logic [bts_pkg::COORD_W-1:0]         c0_r,
  output logic [bts_pkg::COORD_W-1:0]         c1_r,
  output logic [bts_pkg::FRAC_W-1:0]          frac_r
);
  localparam int T_W = bts_pkg::POS_W + bts_pkg::EDGE_W + 1;
  localparam int C_W = bts_pkg::COORD_W + bts_pkg::FRAC_W;

  logic signed [T_W-1:0] t_r, t_nxt;
  logic signed [T_W-1:0] hi;
  logic [C_W-1:0]        c;
  logic [bts_pkg::COORD_W-1:0] c0;

  // Stage A: scale by the edge and step back half a texel.
  always_comb begin
    t_nxt = T_W'(pos) * $signed(T_W'({1'b0, edge_len})) - T_W'(bts_pkg::HALF_TEXEL);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      t_r <= t_nxt;
    end
  end

  // Stage B: clamp to [0, edge-1], then split into texel and fraction.
  always_comb begin
    hi = $signed({{(T_W - bts_pkg::EDGE_W - bts_pkg::FRAC_W){1'b0}},
                  edge_len - bts_pkg::EDGE_W'(1), {bts_pkg::FRAC_W{1'b0}}});
    if (t_r < 0) begin
      c = '0;
    end else if (t_r > hi) begin
      c = hi[C_W-1:0];
    end else begin
      c = t_r[C_W-1:0];
    end
    c0 = c[C_W-1:bts_pkg::FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      c0_r   <= c0;
      frac_r <= c[bts_pkg::FRAC_W-1:0];
      if ((bts_pkg::EDGE_W'(c0) + bts_pkg::EDGE_W'(1)) < edge_len) begin
        c1_r <= c0 + bts_pkg::COORD_W'(1);
      end else begin
        c1_r <= c0;
      end
    end
  end
endmodule

// ===== hdl/bts_texmem.sv =====
// Texel store copy: one write port and two registered read ports.
// Depends on bts_pkg for depth and widths.
module bts_texmem (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic                                we,
  input  logic [bts_pkg::ADDR_W-1:0]          waddr,
  input  logic [bts_pkg::TEXEL_W-1:0]         wdata,
  input  logic [bts_pkg::ADDR_W-1:0]          raddr_a,
  input  logic [bts_pkg::ADDR_W-1:0]          raddr_b,
  output logic [bts_pkg::TEXEL_W-1:0]         rdata_a_r,
  output logic [bts_pkg::TEXEL_W-1:0]         rdata_b_r
);
  logic [bts_pkg::TEXEL_W-1:0] mem [bts_pkg::STORE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, held while the stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end
endmodule

// ===== hdl/bilinear_texel_sampler.sv =====
// Top level of the bilinear texel sampler: pipeline control, addressing, blend.
// Depends on bts_pkg, bts_in_if, bts_out_if, bts_coord and bts_texmem.
//
// A seven-stage pipeline that takes one word per cycle, write or sample, while
// no stage is stalled, and presents each sample on the output. Stages: scale,
// clamp, row multiply, address, store read, X blend, Y blend with rounding. The
// store is kept in two copies with two read ports each so the four neighbor
// texels are read in the same cycle. Writes travel the same pipe and update
// both copies at the read stage, so a sample accepted after a write sees it.
// Writes give no result. Each stage holds its word while the next is full and
// stalled, so bubbles are squeezed out under back-pressure.
module bilinear_texel_sampler (
  input  logic                          clk,
  input  logic                          rst_n,
  bts_in_if.sink                        in_ch,
  bts_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]     cfg_wdata
);
  localparam int AW = bts_pkg::ADDR_W;
  localparam int CW = bts_pkg::COORD_W;
  localparam int TW = bts_pkg::TEXEL_W;
  localparam int FW = bts_pkg::FRAC_W;
  localparam int LW = TW + FW + 1;
  localparam int SW = LW + FW + 2;

  // Configuration registers.
  logic [bts_pkg::EDGE_W-1:0]   edge_cfg_r;
  logic [bts_pkg::STRIDE_W-1:0] stride_cfg_r;
  logic [bts_pkg::EDGE_W-1:0]   edge_eff;
  logic [bts_pkg::STRIDE_W-1:0] stride_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cfg_r   <= bts_pkg::EDGE_W'(bts_pkg::MAX_EDGE);
      stride_cfg_r <= bts_pkg::STRIDE_W'(bts_pkg::MAX_COMPONENTS);
    end else if (cfg_we) begin
      case (cfg_index)
        bts_pkg::CFG_EDGE:   edge_cfg_r   <= cfg_wdata[bts_pkg::EDGE_W-1:0];
        bts_pkg::CFG_STRIDE: stride_cfg_r <= cfg_wdata[bts_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers to the usable range.
  always_comb begin
    if (edge_cfg_r == '0) begin
      edge_eff = bts_pkg::EDGE_W'(1);
    end else if (edge_cfg_r > bts_pkg::EDGE_W'(bts_pkg::MAX_EDGE)) begin
      edge_eff = bts_pkg::EDGE_W'(bts_pkg::MAX_EDGE);
    end else begin
      edge_eff = edge_cfg_r;
    end
    if (stride_cfg_r == '0) begin
      stride_eff = bts_pkg::STRIDE_W'(1);
    end else if (stride_cfg_r > bts_pkg::STRIDE_W'(bts_pkg::MAX_COMPONENTS)) begin
      stride_eff = bts_pkg::STRIDE_W'(bts_pkg::MAX_COMPONENTS);
    end else begin
      stride_eff = stride_cfg_r;
    end
  end

  // Stage valids and per-stage advance enables.
  logic [7:1] v_r;
  logic [7:1] en;

  always_comb begin
    en[7] = !v_r[7] || out_ch.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[1];

  // Word tags travel with the data: sample flag, out-of-range component, write address, write data and component.
  logic [5:1] samp_r;
  logic [6:1] bad_r;
  logic [AW-1:0] waddr_r [1:4];
  logic [TW-1:0] wdata_r [1:4];
  logic [bts_pkg::COMP_W-1:0] comp_r [1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_ch.valid;
      for (int k = 2; k <= 5; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
      // Writes leave the pipe after the store stage.
      if (en[6]) v_r[6] <= v_r[5] && samp_r[5];
      if (en[7]) v_r[7] <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      samp_r[1]  <= (in_ch.kind == bts_pkg::KIND_SAMPLE);
      bad_r[1]   <= (bts_pkg::STRIDE_W'(in_ch.component) >= stride_eff);
      waddr_r[1] <= in_ch.store_address;
      wdata_r[1] <= in_ch.store_value;
      comp_r[1]  <= in_ch.component;
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        samp_r[k]  <= samp_r[k-1];
        bad_r[k]   <= bad_r[k-1];
        waddr_r[k] <= waddr_r[k-1];
        wdata_r[k] <= wdata_r[k-1];
      end
    end
    for (int k = 2; k <= 3; k++) begin
      if (en[k]) comp_r[k] <= comp_r[k-1];
    end
    if (en[5]) begin
      samp_r[5] <= samp_r[4];
      bad_r[5]  <= bad_r[4];
    end
    if (en[6]) bad_r[6] <= bad_r[5];
  end

  // Stages 1 and 2: coordinates for both axes.
  logic [CW-1:0] x0_2, x1_2, y0_2, y1_2;
  logic [FW-1:0] fx_2, fy_2;

  bts_coord u_coord_x (
    .clk(clk), .en_a(en[1]), .en_b(en[2]), .pos(in_ch.pos_x), .edge_len(edge_eff),
    .c0_r(x0_2), .c1_r(x1_2), .frac_r(fx_2)
  );

  bts_coord u_coord_y (
    .clk(clk), .en_a(en[1]), .en_b(en[2]), .pos(in_ch.pos_y), .edge_len(edge_eff),
    .c0_r(y0_2), .c1_r(y1_2), .frac_r(fy_2)
  );

  // Stage 3: row offsets y*edge.
  logic [bts_pkg::ROW_W-1:0] row0_r, row1_r;
  logic [CW-1:0] x0_3_r, x1_3_r;
  logic [FW-1:0] fx_3_r, fy_3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      row0_r <= bts_pkg::ROW_W'(y0_2) * bts_pkg::ROW_W'(edge_eff);
      row1_r <= bts_pkg::ROW_W'(y1_2) * bts_pkg::ROW_W'(edge_eff);
      x0_3_r <= x0_2;
      x1_3_r <= x1_2;
      fx_3_r <= fx_2;
      fy_3_r <= fy_2;
    end
  end

  // Stage 4: linear addresses of the four neighbors.
  logic [AW-1:0] a00_r, a10_r, a01_r, a11_r;
  logic [FW-1:0] fx_4_r, fy_4_r;

  function automatic logic [bts_pkg::ADDR_W-1:0] lin_addr(
    input logic [bts_pkg::ROW_W-1:0]    row,
    input logic [bts_pkg::COORD_W-1:0]  col,
    input logic [bts_pkg::STRIDE_W-1:0] stride,
    input logic [bts_pkg::COMP_W-1:0]   comp
  );
    logic [bts_pkg::ROW_W:0] texel_idx;
    texel_idx = (bts_pkg::ROW_W+1)'(row) + (bts_pkg::ROW_W+1)'(col);
    return bts_pkg::ADDR_W'(texel_idx) * bts_pkg::ADDR_W'(stride)
         + bts_pkg::ADDR_W'(comp);
  endfunction

  always_ff @(posedge clk) begin
    if (en[4]) begin
      a00_r  <= lin_addr(row0_r, x0_3_r, stride_eff, comp_r[3]);
      a10_r  <= lin_addr(row0_r, x1_3_r, stride_eff, comp_r[3]);
      a01_r  <= lin_addr(row1_r, x0_3_r, stride_eff, comp_r[3]);
      a11_r  <= lin_addr(row1_r, x1_3_r, stride_eff, comp_r[3]);
      fx_4_r <= fx_3_r;
      fy_4_r <= fy_3_r;
    end
  end

  // Stage 5: store access; writes update both copies in pipeline order.
  logic          mem_we;
  logic [TW-1:0] t00, t10, t01, t11;
  logic [FW-1:0] fx_5_r, fy_5_r;

  assign mem_we = en[5] && v_r[4] && !samp_r[4];

  bts_texmem u_mem_lo (
    .clk(clk), .rd_en(en[5]), .we(mem_we), .waddr(waddr_r[4]), .wdata(wdata_r[4]),
    .raddr_a(a00_r), .raddr_b(a10_r), .rdata_a_r(t00), .rdata_b_r(t10)
  );

  bts_texmem u_mem_hi (
    .clk(clk), .rd_en(en[5]), .we(mem_we), .waddr(waddr_r[4]), .wdata(wdata_r[4]),
    .raddr_a(a01_r), .raddr_b(a11_r), .rdata_a_r(t01), .rdata_b_r(t11)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      fx_5_r <= fx_4_r;
      fy_5_r <= fy_4_r;
    end
  end

  // Stage 6: X blend as t0*1 + (t1-t0)*fx, exact in Q7.24.
  logic signed [LW-1:0] lower_r, upper_r;
  logic [FW-1:0]        fy_6_r;

  function automatic logic signed [LW-1:0] lerp_x(
    input logic [bts_pkg::TEXEL_W-1:0] a,
    input logic [bts_pkg::TEXEL_W-1:0] b,
    input logic [bts_pkg::FRAC_W-1:0]  f
  );
    logic signed [LW:0] d;
    logic signed [LW:0] p;
    d = (LW+1)'($signed(b)) - (LW+1)'($signed(a));
    p = d * $signed((LW+1)'(f));
    return LW'(((LW+1)'($signed(a)) <<< bts_pkg::FRAC_W) + p);
  endfunction

  always_ff @(posedge clk) begin
    if (en[6]) begin
      lower_r <= lerp_x(t00, t10, fx_5_r);
      upper_r <= lerp_x(t01, t11, fx_5_r);
      fy_6_r  <= fy_5_r;
    end
  end

  // Stage 7: Y blend, then round half up to Q7.8.
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] rounded;
  logic [TW-1:0]        out_val_r;

  always_comb begin
    diff    = SW'(upper_r) - SW'(lower_r);
    sum     = (SW'(lower_r) <<< FW) + diff * $signed(SW'(fy_6_r));
    rounded = (sum + (SW'(1) <<< (2*FW - 1))) >>> (2*FW);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_val_r <= bad_r[6] ? '0 : rounded[TW-1:0];
    end
  end

  assign out_ch.valid        = v_r[7];
  assign out_ch.sample_value = out_val_r;

`ifndef NO_ASSERTIONS
  // After a reset cycle no result is offered.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A component outside the stride yields a zero result.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en[7] && v_r[6] && bad_r[6]) |=> (out_ch.valid && out_ch.sample_value == '0))
    else $error("out-of-range component gave a nonzero sample");

  // A write never reaches the blend stages.
  a_write_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (en[6] && v_r[5] && !samp_r[5]) |=> !v_r[6])
    else $error("write word entered the blend stages");
`endif
endmodule
